// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ihex_enc_pkg.sv =====
package ihex_enc_pkg;

	localparam int MAX_REC_BYTES = 16;
	localparam int REC_BYTES_W = 5;
	localparam int ADDR_W = 16;
	localparam logic [REC_BYTES_W-1:0] REC_BYTES_RST = 5'd16;
	localparam logic [ADDR_W-1:0] BASE_ADDR_RST = 16'h0000;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECORD_BYTES = 1'b0,
		REG_BASE_ADDRESS = 1'b1
	} cfg_reg_t;

	// microprogram
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_DATA_HI = 5'd9;

	typedef enum logic [2:0] {
		SRC_CONST,
		SRC_CNT,
		SRC_AHI,
		SRC_ALO,
		SRC_DATA,
		SRC_CSUM
	} src_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_LOOP,
		JMP_REC_END,
		JMP_FINISH
	} jmp_t;

	typedef struct packed {
		src_t              src;
		logic              hi_nib;
		logic [7:0]        chr;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
		logic              rec_done;
		logic              eof_end;
	} ucode_t;

	typedef struct packed {
		logic loop_more;
		logic eof_pend;
	} seq_cond_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	function automatic ucode_t mk_uw(input src_t src, input logic hi_nib,
			input logic [7:0] chr, input jmp_t jmp, input logic rec_done,
			input logic eof_end);
		ucode_t w;
		w.src      = src;
		w.hi_nib   = hi_nib;
		w.chr      = chr;
		w.jmp      = jmp;
		w.target   = STEP_DATA_HI;
		w.rec_done = rec_done;
		w.eof_end  = eof_end;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			5'd0:  w = mk_uw(SRC_CONST, 1'b0, CH_COLON, JMP_NEXT, 1'b0, 1'b0);
			5'd1:  w = mk_uw(SRC_CNT, 1'b1, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd2:  w = mk_uw(SRC_CNT, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd3:  w = mk_uw(SRC_AHI, 1'b1, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd4:  w = mk_uw(SRC_AHI, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd5:  w = mk_uw(SRC_ALO, 1'b1, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd6:  w = mk_uw(SRC_ALO, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd7:  w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd8:  w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd9:  w = mk_uw(SRC_DATA, 1'b1, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd10: w = mk_uw(SRC_DATA, 1'b0, CH_ZERO, JMP_LOOP, 1'b0, 1'b0);
			5'd11: w = mk_uw(SRC_CSUM, 1'b1, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd12: w = mk_uw(SRC_CSUM, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd13: w = mk_uw(SRC_CONST, 1'b0, CH_CR, JMP_NEXT, 1'b0, 1'b0);
			5'd14: w = mk_uw(SRC_CONST, 1'b0, CH_LF, JMP_REC_END, 1'b1, 1'b0);
			// end-of-file record
			5'd15: w = mk_uw(SRC_CONST, 1'b0, CH_COLON, JMP_NEXT, 1'b0, 1'b0);
			5'd16: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd17: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd18: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd19: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd20: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd21: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd22: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_NEXT, 1'b0, 1'b0);
			5'd23: w = mk_uw(SRC_CONST, 1'b0, CH_ONE, JMP_NEXT, 1'b0, 1'b0);
			5'd24: w = mk_uw(SRC_CONST, 1'b0, CH_F, JMP_NEXT, 1'b0, 1'b0);
			5'd25: w = mk_uw(SRC_CONST, 1'b0, CH_F, JMP_FINISH, 1'b0, 1'b1);
			default: w = mk_uw(SRC_CONST, 1'b0, CH_ZERO, JMP_FINISH, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CH_ZERO + 8'(v);
		end else begin
			c = 8'h41 + 8'(v) - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/intel_hex_record_encoder_top.sv =====
// Intel HEX encoder: image bytes come in one word at a time and are buffered until
// record_bytes of them are held (or one is flagged last); the data record then leaves
// as ASCII, one character per cycle unless out_stall holds it: colon, count, address,
// type 00, data, checksum, CR LF. A last byte also flushes a partial record and
// appends ":00000001FF". A byte that completes no record does not stall the input.
// A microcoded sequencer drives one character per step, and input is stalled while
// it runs. The record buffer is a RAM whose read address advances once per data byte.
module intel_hex_record_encoder_top import ihex_enc_pkg::*; #(
	parameter int MAX_RECORD_BYTES = MAX_REC_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_char,
	output logic                 last_char,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	`include "assert_macros.svh"

	localparam int FILL_W = $clog2(MAX_RECORD_BYTES + 1);
	localparam int IDX_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
	localparam int LEN_W  = (FILL_W > REC_BYTES_W) ? FILL_W : REC_BYTES_W;

	logic [REC_BYTES_W-1:0] record_bytes_q;
	logic [ADDR_W-1:0]      base_address_q;
	logic [ADDR_W-1:0]      record_address_q;
	logic [FILL_W-1:0]      fill_count_q;
	logic [7:0]             data_sum_q;
	logic [FILL_W-1:0]      idx_q;
	logic                   eof_pend_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   last_char_q;

	logic              in_fire;
	logic              start;
	logic              busy;
	logic              emit;
	logic              end_char;
	ucode_t            uw;
	seq_cond_t         cond;
	logic [LEN_W-1:0]  eff_len;
	logic [FILL_W-1:0] fill_next;
	logic [FILL_W-1:0] raddr;
	logic [7:0]        rdata;
	logic [7:0]        src_byte;
	logic [7:0]        csum;
	logic [7:0]        chr;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

	// clamp the record length into 1..MAX_RECORD_BYTES
	always_comb begin
		if (record_bytes_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (LEN_W'(record_bytes_q) > LEN_W'(MAX_RECORD_BYTES)) begin
			eff_len = LEN_W'(MAX_RECORD_BYTES);
		end else begin
			eff_len = LEN_W'(record_bytes_q);
		end
	end

	assign fill_next = fill_count_q + 1'b1;
	assign start     = in_fire && (last_byte || (LEN_W'(fill_next) >= eff_len));

	assign emit     = busy && (!out_valid_q || !out_stall);
	assign end_char = (uw.jmp == JMP_FINISH) || ((uw.jmp == JMP_REC_END) && !eof_pend_q);

	assign cond.loop_more = (idx_q + 1'b1) < fill_count_q;
	assign cond.eof_pend  = eof_pend_q;

	ihex_enc_useq u_useq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.fire  (emit),
		.cond  (cond),
		.busy  (busy),
		.uw    (uw)
	);

	// prefetch the next data word as the low digit leaves
	assign raddr = (emit && (uw.src == SRC_DATA) && !uw.hi_nib) ? idx_q + 1'b1 : idx_q;

	ihex_enc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_RECORD_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (in_fire),
		.waddr(fill_count_q[IDX_W-1:0]),
		.wdata(data_byte),
		.raddr(raddr[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign csum = 8'h00 - (8'(fill_count_q) + record_address_q[15:8]
		+ record_address_q[7:0] + data_sum_q);

	always_comb begin
		case (uw.src)
			SRC_CNT:  src_byte = 8'(fill_count_q);
			SRC_AHI:  src_byte = record_address_q[15:8];
			SRC_ALO:  src_byte = record_address_q[7:0];
			SRC_DATA: src_byte = rdata;
			SRC_CSUM: src_byte = csum;
			default:  src_byte = '0;
		endcase
		if (uw.src == SRC_CONST) begin
			chr = uw.chr;
		end else if (uw.hi_nib) begin
			chr = hex_char(src_byte[7:4]);
		end else begin
			chr = hex_char(src_byte[3:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_bytes_q   <= REC_BYTES_RST;
			base_address_q   <= BASE_ADDR_RST;
			record_address_q <= BASE_ADDR_RST;
			fill_count_q     <= '0;
			data_sum_q       <= '0;
			idx_q            <= '0;
			eof_pend_q       <= 1'b0;
			out_valid_q      <= 1'b0;
			last_char_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_RECORD_BYTES: record_bytes_q <= cfg_data[REC_BYTES_W-1:0];
					REG_BASE_ADDRESS: begin
						base_address_q <= cfg_data;
						if (fill_count_q == '0) begin
							record_address_q <= cfg_data;
						end
					end
					default: ;
				endcase
			end

			if (in_fire) begin
				fill_count_q <= fill_next;
				data_sum_q   <= data_sum_q + data_byte;
				idx_q        <= '0;
				eof_pend_q   <= last_byte;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
				last_char_q <= end_char;
				if ((uw.src == SRC_DATA) && !uw.hi_nib) begin
					idx_q <= idx_q + 1'b1;
				end
				if (uw.rec_done) begin
					record_address_q <= record_address_q + ADDR_W'(fill_count_q);
					fill_count_q     <= '0;
					data_sum_q       <= '0;
				end
				if (uw.eof_end) begin
					record_address_q <= base_address_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= chr;
		end
	end

	`ASSERT_ALWAYS(a_fill_room, (busy || (fill_count_q < FILL_W'(MAX_RECORD_BYTES))), "buffer full while idle")
	`ASSERT_NEXT(a_rec_clear, (emit && uw.rec_done), ((fill_count_q == '0) && (data_sum_q == '0)), "record state not cleared")
	`ASSERT_NEXT(a_end_idle, (emit && end_char), (!busy && out_valid_q && last_char_q), "sequencer still running after final word")

endmodule

// ===== hw/rtl/ihex_enc_ram.sv =====
module ihex_enc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/ihex_enc_useq.sv =====
module ihex_enc_useq import ihex_enc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      fire,
	input  seq_cond_t cond,
	output logic      busy,
	output ucode_t    uw
);

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} sq_state_t;

	sq_state_t         state_q;
	logic [STEP_W-1:0] step_q;

	assign uw   = ucode_rom(step_q);
	assign busy = (state_q == SQ_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					step_q <= '0;
					if (start) begin
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					if (fire) begin
						case (uw.jmp)
							JMP_NEXT: step_q <= step_q + 1'b1;
							JMP_LOOP: begin
								step_q <= cond.loop_more ? uw.target : step_q + 1'b1;
							end
							JMP_REC_END: begin
								if (cond.eof_pend) begin
									step_q <= step_q + 1'b1;
								end else begin
									step_q  <= '0;
									state_q <= SQ_IDLE;
								end
							end
							default: begin
								step_q  <= '0;
								state_q <= SQ_IDLE;
							end
						endcase
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

endmodule

// ===== sim/intel_hex_record_encoder_top_tb.sv =====
module intel_hex_record_encoder_top_tb import ihex_enc_pkg::*;;

	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 410;

	// Expected text of the encoder: {last_char, out_char} per character.
	class hex_text_sb;
		logic [7:0]  rec_buf [MAX_REC_BYTES];
		logic [4:0]  fill;
		logic [15:0] rec_addr;
		logic [15:0] base_addr;
		logic [4:0]  len_reg;
		logic [7:0]  data_sum;
		logic [8:0]  text_q [$];
		int          errors;

		function new();
			fill      = '0;
			len_reg   = REC_BYTES_RST;
			base_addr = BASE_ADDR_RST;
			rec_addr  = BASE_ADDR_RST;
			data_sum  = '0;
			errors    = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] val);
			if (idx == REG_RECORD_BYTES) begin
				len_reg = val[4:0];
			end else begin
				base_addr = val;
				// an open record keeps its address until the end of the image
				if (fill == 0) rec_addr = val;
			end
		endfunction

		function void put_char(logic [7:0] ch);
			text_q.insert(text_q.size(), {1'b0, ch});
		endfunction

		function logic [7:0] digit(logic [3:0] nib);
			return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
		endfunction

		function void put_hex(logic [7:0] v);
			put_char(digit(v[7:4]));
			put_char(digit(v[3:0]));
		endfunction

		function void flush_record();
			logic [7:0] sum;
			sum = 8'(fill) + rec_addr[15:8] + rec_addr[7:0] + data_sum;
			put_char(":");
			put_hex(8'(fill));
			put_hex(rec_addr[15:8]);
			put_hex(rec_addr[7:0]);
			put_hex(8'h00);
			for (int i = 0; i < fill; i++) put_hex(rec_buf[i]);
			put_hex(8'h00 - sum);
			put_char(8'h0D);
			put_char(8'h0A);
			rec_addr = rec_addr + 16'(fill);
			fill     = '0;
			data_sum = '0;
		endfunction

		function void encode_byte(logic [7:0] d, logic l);
			int         first;
			int         span;
			logic [8:0] tail;
			string      eof_text;
			first    = text_q.size();
			eof_text = ":00000001FF";
			// zero acts as one, oversize clamps to the buffer depth
			span = (len_reg == 0) ? 1 : (len_reg > MAX_REC_BYTES) ? MAX_REC_BYTES : int'(len_reg);
			if (fill < MAX_REC_BYTES) begin
				rec_buf[fill] = d;
				fill++;
				data_sum += d;
			end
			if (fill >= span) flush_record();
			if (l) begin
				if (fill != 0) flush_record();
				for (int i = 0; i < eof_text.len(); i++) put_char(eof_text[i]);
				fill     = '0;
				data_sum = '0;
				rec_addr = base_addr;
			end
			// flag the final character of this word
			if (text_q.size() > first) begin
				tail = text_q.pop_back();
				text_q.insert(text_q.size(), {1'b1, tail[7:0]});
			end
		endfunction

		function void check_char(logic [7:0] ch, logic lc);
			logic [8:0] want;
			if (text_q.size() == 0) begin
				$error("out_char: expected none, actual 0x%02h", ch);
				errors++;
			end else begin
				want = text_q.pop_front();
				if (ch !== want[7:0]) begin
					$error("out_char: expected 0x%02h, actual 0x%02h", want[7:0], ch);
					errors++;
				end
				if (lc !== want[8]) begin
					$error("last_char: expected %0d, actual %0d", want[8], lc);
					errors++;
				end
			end
		endfunction

		function int pending();
			return text_q.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           out_char;
	logic                 last_char;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data  = '0;

	hex_text_sb text_sb;
	bit         hold_req   = 1'b0;
	bit         no_idle    = 1'b0;
	int         burst_left = 0;
	int         sent       = 0;

	intel_hex_record_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last_char (last_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic push_byte(input logic [7:0] d, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = no_idle ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		text_sb.encode_byte(d, l);
		sent++;
	endtask

	// Drop valid and wait until all expected text is out and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (text_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] len_word, input logic [15:0] base,
			input bit with_base);
		cfg_valid <= 1'b1;
		cfg_index <= REG_RECORD_BYTES;
		cfg_data  <= len_word;
		do @(posedge clk); while (!cfg_ready);
		text_sb.write_reg(REG_RECORD_BYTES, len_word);
		if (with_base) begin
			cfg_index <= REG_BASE_ADDRESS;
			cfg_data  <= base;
			do @(posedge clk); while (!cfg_ready);
			text_sb.write_reg(REG_BASE_ADDRESS, base);
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) text_sb.check_char(out_char, last_char);
	end

	initial begin : receiver
		int hold_left;
		int seg_left;
		int mode;
		int cyc;
		bit stall_nxt;
		hold_left = 0;
		seg_left  = 0;
		mode      = 0;
		cyc       = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left > 0) begin
				stall_nxt = 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				stall_nxt = 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 150);
				end
				seg_left--;
				case (mode)
					0: stall_nxt = 1'b0;
					1: stall_nxt = ($urandom_range(0, 3) == 0);
					2: stall_nxt = 1'($urandom_range(0, 1));
					default: stall_nxt = ((cyc % 5) < 2);
				endcase
			end
			out_stall <= stall_nxt;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("intel_hex_record_encoder_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		int          phase;
		int          n_img;
		int          mid_at;
		logic [15:0] w;
		logic [15:0] ba;
		logic        lastf;
		text_sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte records from the top of memory: address wraps to zero
		set_regs(16'd1, 16'hFFFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		settle();
		// zero length acts as one; upper data bits are ignored
		set_regs(16'hFFE0, 16'h0000, 1'b0);
		push_byte(8'hA5, 1'b1);
		settle();
		// length 31 clamps to full depth
		set_regs(16'hFFFF, 16'h1234, 1'b1);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h96, 1'b0);
		settle();
		// shorten below the fill level; the new base waits for the end of image
		set_regs(16'd3, 16'hABCD, 1'b1);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h81, 1'b1);
		settle();
		// record completes on the last byte, then a lone last byte
		set_regs(16'd2, 16'h0000, 1'b0);
		push_byte(8'h10, 1'b0);
		push_byte(8'hEF, 1'b1);
		push_byte(8'h55, 1'b1);
		settle();

		phase = 0;
		sent  = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			w = 16'($urandom());
			case ($urandom_range(0, 9))
				0: w[4:0] = 5'd0;
				1: w[4:0] = 5'($urandom_range(17, 31));
				2, 3: w[4:0] = 5'd16;
				default: w[4:0] = 5'($urandom_range(1, 15));
			endcase
			case ($urandom_range(0, 5))
				0: ba = 16'hFFFF - 16'($urandom_range(0, 40));
				1: ba = 16'h0000;
				default: ba = 16'($urandom());
			endcase
			set_regs(w, ba, $urandom_range(0, 4) != 0);
			n_img = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 36);
			if (phase == 2) begin
				// stall the output for a long stretch while input keeps coming
				no_idle  = 1'b1;
				n_img    = 60;
				hold_req = 1'b1;
			end
			mid_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_img) : 0;
			for (int k = 1; k <= n_img; k++) begin
				if (k == mid_at) begin
					settle();
					w = 16'($urandom());
					if (text_sb.fill > 1 && $urandom_range(0, 1) == 1)
						w[4:0] = 5'($urandom_range(1, text_sb.fill));
					set_regs(w, 16'($urandom()), 1'($urandom_range(0, 1)));
				end
				lastf = (k == n_img) && ($urandom_range(0, 7) != 0);
				push_byte(8'($urandom()), lastf);
			end
			settle();
			phase++;
		end

		repeat (40) @(posedge clk);
		if (text_sb.errors == 0 && text_sb.pending() == 0) begin
			$display("intel_hex_record_encoder_top regression: pass");
		end else begin
			$display("intel_hex_record_encoder_top regression: fail");
		end
		$finish;
	end

endmodule
